/* rtl/bdlp_pkg.sv */
// Shared types and constants of the button debounce and long-press block.
package bdlp_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// Register values after reset.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;

	// Register select, taken from address bit 2.
	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	// Bit positions in the pending flags and in the acknowledge mask.
	localparam int unsigned FLAG_MODE_CLICK  = 0;
	localparam int unsigned FLAG_MODE_LONG   = 1;
	localparam int unsigned FLAG_PLUS_CLICK  = 2;
	localparam int unsigned FLAG_MINUS_CLICK = 3;
	localparam int unsigned FLAG_W           = 4;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic click;
		logic long_press;
	} mode_evt_t;

endpackage

/* rtl/button_debounce_long_press.sv */
// Top level of the three-button debouncer with mode long-press detection.
// One sample is accepted every clock cycle while in_stall is low; each sample gives
// one result, passing through the input register and then the result register,
// with all flag updates done in the single combinational pass between them. A
// held result does not block intake: the input register still takes a sample while
// the result register is full, and in_stall rises only when both are full and
// out_stall is high. The debounce time (address 0) and the long-press time (address
// 4) are 16-bit millisecond values written over the APB port; the user must write
// them while no sample is in flight, which the block does not enforce; timestamps wrap modulo 2^32.
module button_debounce_long_press (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdlp_pkg::ADDR_W-1:0]   paddr,
	input  logic [bdlp_pkg::DATA_W-1:0]   pwdata,
	output logic [bdlp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdlp_pkg::TIME_W-1:0]   time_ms,
	input  logic                          mode_level,
	input  logic                          plus_level,
	input  logic                          minus_level,
	input  logic [bdlp_pkg::FLAG_W-1:0]   ack_mask,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          mode_click,
	output logic                          mode_long,
	output logic                          plus_click,
	output logic                          minus_click
);
	import bdlp_pkg::*;

	cfg_t              cfg;
	mode_evt_t         mode_evt;
	logic              valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic              mode_level_s1;
	logic              plus_level_s1;
	logic              minus_level_s1;
	logic [FLAG_W-1:0] ack_s1;
	logic              advance;
	logic              in_take;
	logic              plus_press;
	logic              minus_press;
	logic [FLAG_W-1:0] pending_q;
	logic [FLAG_W-1:0] flags_now;
	logic              out_valid_q;
	logic [FLAG_W-1:0] out_flags_q;

	bdlp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the sample in stage 1 moves on whenever the result slot frees.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			time_s1        <= time_ms;
			mode_level_s1  <= mode_level;
			plus_level_s1  <= plus_level;
			minus_level_s1 <= minus_level;
			ack_s1         <= ack_mask;
		end
	end

	bdlp_mode_btn u_mode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.level        (mode_level_s1),
		.now          (time_s1),
		.cfg          (cfg),
		.long_pending (pending_q[FLAG_MODE_LONG]),
		.evt          (mode_evt)
	);

	bdlp_simple_btn u_plus (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.level       (plus_level_s1),
		.now         (time_s1),
		.debounce_ms (cfg.debounce_ms),
		.press       (plus_press)
	);

	bdlp_simple_btn u_minus (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.level       (minus_level_s1),
		.now         (time_s1),
		.debounce_ms (cfg.debounce_ms),
		.press       (minus_press)
	);

	// Flags reported for this sample: pending ones plus new events.
	always_comb begin
		flags_now                   = pending_q;
		flags_now[FLAG_MODE_CLICK]  = pending_q[FLAG_MODE_CLICK] | mode_evt.click;
		flags_now[FLAG_MODE_LONG]   = pending_q[FLAG_MODE_LONG] | mode_evt.long_press;
		flags_now[FLAG_PLUS_CLICK]  = pending_q[FLAG_PLUS_CLICK] | plus_press;
		flags_now[FLAG_MINUS_CLICK] = pending_q[FLAG_MINUS_CLICK] | minus_press;
	end

	// Pending flags drop the acknowledged bits after each report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (advance) begin
			pending_q <= flags_now & ~ack_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_flags_q <= flags_now;
		end
	end

	assign out_valid   = out_valid_q;
	assign mode_click  = out_flags_q[FLAG_MODE_CLICK];
	assign mode_long   = out_flags_q[FLAG_MODE_LONG];
	assign plus_click  = out_flags_q[FLAG_PLUS_CLICK];
	assign minus_click = out_flags_q[FLAG_MINUS_CLICK];

endmodule

/* rtl/bdlp_cfg.sv */
// APB register file holding the debounce and long-press times.
module bdlp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdlp_pkg::ADDR_W-1:0]   paddr,
	input  logic [bdlp_pkg::DATA_W-1:0]   pwdata,
	output logic [bdlp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bdlp_pkg::cfg_t                cfg
);
	import bdlp_pkg::*;

	logic             wr_en;
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes complete in the access phase of a transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_DEBOUNCE:   debounce_q   <= pwdata[CFG_W-1:0];
				REG_LONG_PRESS: long_press_q <= pwdata[CFG_W-1:0];
				default:        debounce_q   <= debounce_q;
			endcase
		end
	end

	// Read data is zero-extended to the bus width.
	always_comb begin
		case (paddr[2])
			REG_DEBOUNCE:   prdata = {{(DATA_W-CFG_W){1'b0}}, debounce_q};
			REG_LONG_PRESS: prdata = {{(DATA_W-CFG_W){1'b0}}, long_press_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.debounce_ms   = debounce_q;
	assign cfg.long_press_ms = long_press_q;

endmodule

/* rtl/bdlp_simple_btn.sv */
// Debouncer for one plain button that reports accepted presses.
module bdlp_simple_btn (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          level,
	input  logic [bdlp_pkg::TIME_W-1:0]   now,
	input  logic [bdlp_pkg::CFG_W-1:0]    debounce_ms,
	output logic                          press
);
	import bdlp_pkg::*;

	logic              prev_q;
	logic [TIME_W-1:0] edge_time_q;
	logic [TIME_W-1:0] since_edge;
	logic              changed;
	logic              accepted;

	// An edge counts only when more than the debounce time has elapsed.
	assign changed    = level != prev_q;
	assign since_edge = now - edge_time_q;
	assign accepted   = changed && (since_edge > {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
	assign press      = step && accepted && !level;

	// The stored level follows every change; the edge time only accepted ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b1;
			edge_time_q <= '0;
		end else if (step) begin
			prev_q <= level;
			if (accepted) begin
				edge_time_q <= now;
			end
		end
	end

endmodule

/* rtl/bdlp_mode_btn.sv */
// Debouncer for the mode button with short-click and long-press detection.
module bdlp_mode_btn (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          level,
	input  logic [bdlp_pkg::TIME_W-1:0]   now,
	input  bdlp_pkg::cfg_t                cfg,
	input  logic                          long_pending,
	output bdlp_pkg::mode_evt_t           evt
);
	import bdlp_pkg::*;

	logic              prev_q;
	logic [TIME_W-1:0] edge_time_q;
	logic              holding_q;
	logic [TIME_W-1:0] hold_start_q;
	logic [TIME_W-1:0] since_edge;
	logic [TIME_W-1:0] since_hold;
	logic [TIME_W-1:0] debounce_ext;
	logic [TIME_W-1:0] long_ext;
	logic              accepted;
	logic              press;
	logic              release_hold;
	logic              holding_mid;
	logic [TIME_W-1:0] hold_age;
	logic              long_hit;

	assign debounce_ext = {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
	assign long_ext     = {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};

	// Edge qualification against the debounce time.
	assign since_edge   = now - edge_time_q;
	assign since_hold   = now - hold_start_q;
	assign accepted     = (level != prev_q) && (since_edge > debounce_ext);
	assign press        = accepted && !level;
	assign release_hold = accepted && level && holding_q;

	// Hold state after the edge; a fresh press has zero age.
	assign holding_mid = press || (holding_q && !release_hold);
	assign hold_age    = press ? '0 : since_hold;
	assign long_hit    = holding_mid && !long_pending && (hold_age >= long_ext);

	assign evt.click      = step && release_hold && (since_hold < long_ext);
	assign evt.long_press = step && long_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= 1'b1;
			edge_time_q  <= '0;
			holding_q    <= 1'b0;
			hold_start_q <= '0;
		end else if (step) begin
			prev_q    <= level;
			holding_q <= holding_mid && !long_hit;
			if (accepted) begin
				edge_time_q <= now;
			end
			if (press) begin
				hold_start_q <= now;
			end
		end
	end

endmodule

/* rtl/bdlp_checker.sv */
// Port-level checks for the button debouncer, bound to the top level.
module bdlp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic mode_click,
	input logic mode_long,
	input logic plus_click,
	input logic minus_click
);

	// A result waiting on a stall stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// Intake stops only when a finished result is itself being held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result side is free");

	// A new result must trace back to an accepted sample transaction.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching sample");

	// Reported flags do not change while the result is stalled.
	a_flags_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			$stable({mode_click, mode_long, plus_click, minus_click}))
		else $error("result flags changed while stalled");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.mode_click  (mode_click),
	.mode_long   (mode_long),
	.plus_click  (plus_click),
	.minus_click (minus_click)
);

/* test/tb_button_debounce_long_press.sv */
// Self-checking testbench for the three-button debouncer with mode long-press detection.
`timescale 1ns / 100ps

module tb_button_debounce_long_press;
	import bdlp_pkg::*;

	localparam int BTN_MODE  = 0;
	localparam int BTN_PLUS  = 1;
	localparam int BTN_MINUS = 2;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_SAMPLES = 305;
	localparam int MAX_PRINTED = 100;
	localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE   = {REG_DEBOUNCE, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_LONG_PRESS = {REG_LONG_PRESS, 2'b00};

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [ADDR_W-1:0]   paddr       = '0;
	logic [DATA_W-1:0]   pwdata      = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [TIME_W-1:0]   time_ms     = '0;
	logic                mode_level  = 1'b1;
	logic                plus_level  = 1'b1;
	logic                minus_level = 1'b1;
	logic [FLAG_W-1:0]   ack_mask    = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic                mode_click;
	logic                mode_long;
	logic                plus_click;
	logic                minus_click;

	// Predictor copy of the configuration and of the button state.
	logic [CFG_W-1:0]    cfg_debounce;
	logic [CFG_W-1:0]    cfg_long_press;
	logic                level_seen [3];
	logic [TIME_W-1:0]   edge_at [3];
	logic                holding;
	logic [TIME_W-1:0]   hold_from;
	logic [FLAG_W-1:0]   pending;
	logic [FLAG_W-1:0]   flags_due [$];

	// Last sample sent, which the random sequences build on.
	logic [TIME_W-1:0]   now_ms;
	logic                drive_level [3];

	string               flag_names [FLAG_W];
	int                  send_idle_pct  = 26;
	int                  recv_stall_pct = 67;
	int                  samples_sent   = 0;
	int                  results_seen   = 0;
	int                  settings_used  = 1;
	int                  mismatches     = 0;
	int                  quiet_cycles   = 0;

	button_debounce_long_press dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver side: random stall per cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: %0d cycles with no transaction, %0d results outstanding",
				quiet_cycles, flags_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endtask

	// Compares every accepted result with the oldest predicted flag set.
	always @(posedge clk) begin : check_results
		logic [FLAG_W-1:0] got;
		logic [FLAG_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			got[FLAG_MODE_CLICK]  = mode_click;
			got[FLAG_MODE_LONG]   = mode_long;
			got[FLAG_PLUS_CLICK]  = plus_click;
			got[FLAG_MINUS_CLICK] = minus_click;
			if (flags_due.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no transaction waiting",
					results_seen));
			end else begin
				want = flags_due.pop_front();
				for (int i = 0; i < FLAG_W; i++) begin
					if (got[i] !== want[i]) begin
						report_mismatch($sformatf("result %0d %s: expected %b, got %b",
							results_seen, flag_names[i], want[i], got[i]));
					end
				end
			end
			results_seen++;
		end
	end

	// Accepts one level change if the debounce time has passed since the last accepted edge.
	function automatic logic accept_edge(input int btn, input logic lv, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] elapsed;
		logic taken;
		elapsed = t - edge_at[btn];
		taken = 1'b0;
		if (lv != level_seen[btn]) begin
			if (elapsed > TIME_W'(cfg_debounce)) begin
				taken = 1'b1;
				edge_at[btn] = t;
			end
			level_seen[btn] = lv;
		end
		return taken;
	endfunction

	// Advances the predicted state by one sample and returns the flags it reports.
	function automatic logic [FLAG_W-1:0] predict_flags(input logic [TIME_W-1:0] t,
			input logic m, input logic p, input logic n, input logic [FLAG_W-1:0] ack);
		logic [TIME_W-1:0] held;
		logic [FLAG_W-1:0] shown;
		if (accept_edge(BTN_MODE, m, t)) begin
			if (!m) begin
				holding = 1'b1;
				hold_from = t;
			end else if (holding) begin
				held = t - hold_from;
				if (held < TIME_W'(cfg_long_press)) begin
					pending[FLAG_MODE_CLICK] = 1'b1;
				end
				holding = 1'b0;
			end
		end
		// A hold turns long only while no long press is waiting to be acknowledged.
		held = t - hold_from;
		if (holding && !pending[FLAG_MODE_LONG] && held >= TIME_W'(cfg_long_press)) begin
			pending[FLAG_MODE_LONG] = 1'b1;
			holding = 1'b0;
		end
		if (accept_edge(BTN_PLUS, p, t) && !p) begin
			pending[FLAG_PLUS_CLICK] = 1'b1;
		end
		if (accept_edge(BTN_MINUS, n, t) && !n) begin
			pending[FLAG_MINUS_CLICK] = 1'b1;
		end
		shown = pending;
		pending = pending & ~ack;
		return shown;
	endfunction

	// Sends one sample, idling at random first, and records its expected flags.
	task automatic send_sample(input logic [TIME_W-1:0] t, input logic m, input logic p,
			input logic n, input logic [FLAG_W-1:0] ack);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		time_ms     <= t;
		mode_level  <= m;
		plus_level  <= p;
		minus_level <= n;
		ack_mask    <= ack;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		flags_due.push_back(predict_flags(t, m, p, n, ack));
		samples_sent++;
		now_ms = t;
		drive_level[BTN_MODE]  = m;
		drive_level[BTN_PLUS]  = p;
		drive_level[BTN_MINUS] = n;
	endtask

	// Drops valid and waits until every predicted result has been checked.
	task automatic drain;
		in_valid <= 1'b0;
		while (flags_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_DEBOUNCE) begin
			cfg_debounce = value;
		end else begin
			cfg_long_press = value;
		end
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] long_press);
		drain();
		write_reg(ADDR_DEBOUNCE, debounce);
		write_reg(ADDR_LONG_PRESS, long_press);
		settings_used++;
	endtask

	// Mostly no acknowledge, so that flags stay pending for a while.
	function automatic logic [FLAG_W-1:0] pick_ack();
		if ($urandom_range(0, 2) == 0) begin
			return FLAG_W'($urandom_range(0, 15));
		end
		return '0;
	endfunction

	task automatic advance(input logic [TIME_W-1:0] dt);
		send_sample(now_ms + dt, drive_level[BTN_MODE], drive_level[BTN_PLUS],
			drive_level[BTN_MINUS], pick_ack());
	endtask

	// Moves to an absolute time, or stays put if that time has already passed.
	task automatic hop_to(input logic [TIME_W-1:0] target);
		logic [TIME_W-1:0] dt;
		dt = target - now_ms;
		if (dt[TIME_W-1]) begin
			dt = '0;
		end
		advance(dt);
	endtask

	task automatic release_if_pressed(input int btn);
		if (!drive_level[btn]) begin
			drive_level[btn] = 1'b1;
			advance(TIME_W'(cfg_debounce) + 1);
		end
	endtask

	// Contact bounce: pairs of level flips that all fall inside the debounce window.
	task automatic bounce(input int btn);
		int pairs;
		int unsigned step;
		pairs = $urandom_range(0, 2);
		for (int i = 0; i < pairs; i++) begin
			step = $urandom_range(0, cfg_debounce / 4);
			drive_level[btn] = ~drive_level[btn];
			advance(step);
			drive_level[btn] = ~drive_level[btn];
			advance(step);
		end
	endtask

	// A mode press held for a time around the long-press boundary.
	task automatic random_mode_hold;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] lp;
		logic [TIME_W-1:0] d;
		release_if_pressed(BTN_MODE);
		drive_level[BTN_MODE] = 1'b0;
		advance(TIME_W'(cfg_debounce) + 1 + $urandom_range(0, 20));
		start = now_ms;
		bounce(BTN_MODE);
		lp = TIME_W'(cfg_long_press);
		case ($urandom_range(0, 5))
			0: d = (lp == 0) ? '0 : lp - 1;
			1: d = lp;
			2: d = lp + 1;
			3: d = $urandom_range(0, lp);
			4: d = lp + $urandom_range(0, lp);
			default: d = $urandom_range(0, TIME_W'(cfg_debounce) + 2);
		endcase
		if ($urandom_range(0, 2) == 0) begin
			hop_to(start + d / 2);
		end
		if ($urandom_range(0, 3) != 0) begin
			drive_level[BTN_MODE] = 1'b1;
		end
		hop_to(start + d);
		if ($urandom_range(0, 3) == 0) begin
			bounce(BTN_MODE);
		end
	endtask

	// A plus or minus press released around the debounce boundary.
	task automatic random_click(input int btn);
		int unsigned deb;
		deb = 32'(cfg_debounce);
		release_if_pressed(btn);
		drive_level[btn] = 1'b0;
		advance(deb + 1 + $urandom_range(0, 10));
		bounce(btn);
		drive_level[btn] = 1'b1;
		case ($urandom_range(0, 2))
			0: advance(deb);
			1: advance(deb + 1);
			default: advance($urandom_range(0, 2 * deb + 3));
		endcase
		bounce(btn);
	endtask

	// Arbitrary levels, time jumps of any size and any acknowledge mask.
	task automatic random_noise;
		int count;
		logic [TIME_W-1:0] dt;
		count = $urandom_range(1, 3);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: dt = $urandom;
				1, 2, 3, 4: dt = $urandom_range(0, cfg_debounce + 2);
				default: dt = $urandom_range(0, cfg_long_press + 2);
			endcase
			send_sample(now_ms + dt, 1'($urandom), 1'($urandom), 1'($urandom),
				FLAG_W'($urandom_range(0, 15)));
		end
	endtask

	task automatic run_random_phase(input logic [CFG_W-1:0] debounce,
			input logic [CFG_W-1:0] long_press);
		int first;
		int kind;
		set_config(debounce, long_press);
		first = samples_sent;
		while (samples_sent - first < PHASE_SAMPLES) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				random_mode_hold();
			end else if (kind < 6) begin
				random_click(BTN_PLUS);
			end else if (kind < 8) begin
				random_click(BTN_MINUS);
			end else begin
				random_noise();
			end
		end
	endtask

	// Reset values of the registers: edges at, well below and just above 50 ms.
	task automatic test_debounce_window;
		send_sample(32'd0,   1'b1, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd50,  1'b1, 1'b0, 1'b1, 4'b0000);
		send_sample(32'd60,  1'b1, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd111, 1'b1, 1'b0, 1'b0, 4'b0000);
		send_sample(32'd112, 1'b1, 1'b1, 1'b0, 4'b0100);
		send_sample(32'd113, 1'b1, 1'b1, 1'b0, 4'b1000);
		send_sample(32'd162, 1'b1, 1'b0, 1'b1, 4'b1111);
	endtask

	// Short click, long press, release without a hold, and a hold while a long press waits.
	task automatic test_mode_press;
		send_sample(32'd200,  1'b0, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd700,  1'b1, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd1000, 1'b0, 1'b1, 1'b1, 4'b0001);
		send_sample(32'd3000, 1'b0, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd3100, 1'b1, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd3200, 1'b0, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd4000, 1'b0, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd4500, 1'b1, 1'b1, 1'b1, 4'b0000);
		send_sample(32'd4600, 1'b0, 1'b1, 1'b1, 4'b0010);
		send_sample(32'd6600, 1'b0, 1'b1, 1'b1, 4'b0001);
		send_sample(32'd6640, 1'b1, 1'b1, 1'b1, 4'b1111);
	endtask

	// Timestamps that wrap past the top of the 32-bit range.
	task automatic test_time_wrap;
		send_sample(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1, 4'b0000);
		send_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 4'b0000);
		send_sample(32'h0000_0010, 1'b1, 1'b0, 1'b1, 4'b0000);
		send_sample(32'h0000_0023, 1'b1, 1'b1, 1'b1, 4'b1111);
	endtask

	// Zero debounce and zero long-press time, then both at full scale.
	task automatic test_config_extremes;
		set_config(16'd0, 16'd0);
		send_sample(32'h0000_0030, 1'b0, 1'b1, 1'b1, 4'b0000);
		send_sample(32'h0000_0031, 1'b1, 1'b0, 1'b0, 4'b0000);
		send_sample(32'h0000_0032, 1'b0, 1'b1, 1'b1, 4'b0000);
		send_sample(32'h0000_0033, 1'b1, 1'b1, 1'b1, 4'b1111);
		set_config(16'hFFFF, 16'hFFFF);
		send_sample(32'h0001_0032, 1'b0, 1'b0, 1'b1, 4'b0000);
		send_sample(32'h0001_0034, 1'b1, 1'b1, 1'b1, 4'b1111);
	endtask

	// Random sequences under several settings and all three idle patterns.
	task automatic test_random_traffic;
		send_idle_pct  = 26;
		recv_stall_pct = 67;
		run_random_phase(CFG_W'($urandom_range(0, 100)), CFG_W'($urandom_range(1, 400)));
		run_random_phase(16'hFFFF, 16'hFFFF);
		send_idle_pct  = 67;
		recv_stall_pct = 26;
		run_random_phase(16'd0, 16'd1);
		run_random_phase(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(1, 65535)));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_phase(DEBOUNCE_RST, LONG_PRESS_RST);
		run_random_phase(16'd1, CFG_W'($urandom_range(1, 60)));
	endtask

	initial begin
		flag_names[FLAG_MODE_CLICK]  = "mode_click";
		flag_names[FLAG_MODE_LONG]   = "mode_long";
		flag_names[FLAG_PLUS_CLICK]  = "plus_click";
		flag_names[FLAG_MINUS_CLICK] = "minus_click";
		cfg_debounce   = DEBOUNCE_RST;
		cfg_long_press = LONG_PRESS_RST;
		for (int i = 0; i < 3; i++) begin
			level_seen[i]  = 1'b1;
			edge_at[i]     = '0;
			drive_level[i] = 1'b1;
		end
		holding   = 1'b0;
		hold_from = '0;
		pending   = '0;
		now_ms    = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_debounce_window();
		test_mode_press();
		test_time_wrap();
		test_config_extremes();
		test_random_traffic();
		drain();

		$display("Checked %0d results from %0d samples over %0d register settings,",
			results_seen, samples_sent, settings_used);
		$display("including zero and full-scale times, wrapped timestamps and bounce.");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/bdlp_pkg.sv
rtl/bdlp_cfg.sv
rtl/bdlp_simple_btn.sv
rtl/bdlp_mode_btn.sv
rtl/button_debounce_long_press.sv
rtl/bdlp_checker.sv
test/tb_button_debounce_long_press.sv
